// ===== design/cppr_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera picture packet receiver: shared types and constants
// Request, result and status codes, protocol bytes and the result descriptor
// that passes from the protocol engine to the beat sequencer.
// ----------------------------------------------------------------------------
package cppr_pkg;

	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_BYTE    = 2'd1,
		REQ_TIMEOUT = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_WR   = 2'd1,
		KIND_STAT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD     = 3'd1,
		ST_NOMEM   = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_OVERRUN = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ACK    = 4'd1,
		PH_LEN    = 4'd2,
		PH_HDR    = 4'd3,
		PH_DATA   = 4'd4,
		PH_VERIFY = 4'd5
	} phase_t;

	localparam logic CFG_PACKET_SIZE = 1'b0;
	localparam logic CFG_CAPACITY    = 1'b1;

	localparam logic [7:0] BYTE_SYNC    = 8'hAA;
	localparam logic [7:0] BYTE_ACK     = 8'h0E;
	localparam logic [7:0] BYTE_GET_PIC = 8'h04;
	localparam logic [7:0] BYTE_LENGTH  = 8'h0A;
	localparam logic [7:0] BYTE_ONE     = 8'h01;
	localparam logic [7:0] BYTE_END     = 8'hF0;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;

	localparam int          FRAME_BYTES   = 6;
	localparam logic [23:0] PACKET_OVHD   = 24'd6;
	localparam logic [2:0]  FRAME_BEATS   = 3'd6;

	typedef struct packed {
		logic              tx6;
		logic              wr;
		logic              stat;
		logic [4:0][7:0]   tx;
		logic [23:0]       addr;
		logic [7:0]        data;
		status_t           st;
		logic [23:0]       size;
		logic [2:0]        nbeats;
	} desc_t;

	function automatic desc_t frame_desc(input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
		desc_t d;
		d = '0;
		d.tx6 = 1'b1;
		d.tx[0] = b1;
		d.tx[1] = b2;
		d.tx[2] = b3;
		d.tx[3] = b4;
		d.tx[4] = b5;
		d.nbeats = FRAME_BEATS;
		return d;
	endfunction

	function automatic desc_t add_status(input desc_t din, input status_t st,
			input logic [23:0] size);
		desc_t d;
		d = din;
		d.stat = 1'b1;
		d.st = st;
		d.size = size;
		d.nbeats = din.nbeats + 3'd1;
		return d;
	endfunction

endpackage

// ===== design/camera_picture_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// Camera picture packet receiver
// Picture download engine for a serial camera with packet transfer.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is a start request, a byte received from the
// camera or a receive timeout. The engine updates its protocol state in the
// cycle the beat is taken and queues the results as one descriptor; an output
// sequencer then sends them as master beats, one per cycle while m_tready is
// high: transmit bytes for the camera, image buffer writes and a final status
// with the image size. A beat that causes no result or one result is taken
// every cycle while the output is not stalled; a beat that causes n results
// occupies the output for n beats (six for a command or packet acknowledge,
// seven at the end of the image), and one descriptor can wait in a pending
// slot while the sequencer works, so the next beat is taken even while the
// output is stalled. The limit is the one-beat-per-cycle output sequencer.
module camera_picture_packet_receiver #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // tx_byte, write_addr, write_data, status, image_size
	output logic [1:0]  m_tuser,  // out_kind
	output logic        m_tlast
);

	localparam int LEN_W = LENGTH_BITS;
	localparam int SUM_W = LENGTH_BITS + 1;

	logic [9:0]             fps_q;
	logic [23:0]            cap_q;
	cppr_pkg::phase_t       phase_q, phase_d;
	logic [2:0]             fbc_q, fbc_d;
	logic [LEN_W-1:0]       exp_q, exp_d;
	logic [LEN_W-1:0]       tot_q, tot_d;
	logic [15:0]            pn_q, pn_d;
	logic [15:0]            size_q, size_d;
	logic [15:0]            idx_q, idx_d;
	logic [23:0]            base_q, base_d;

	cppr_pkg::desc_t        pend_q, desc_d;
	logic                   pend_vld_q;
	logic                   take;
	logic                   accept;
	cppr_pkg::req_t         req;
	logic [7:0]             rx;
	logic [23:0]            step;
	logic [SUM_W-1:0]       sum;
	logic [31:0]            tot_ext;
	logic [31:0]            len_ext;
	logic                   bad_hdr;

	assign accept  = s_tvalid && s_tready;
	assign s_tready = !pend_vld_q || take;
	assign req     = cppr_pkg::req_t'(s_tuser);
	assign rx      = s_tdata;
	assign step    = 24'(fps_q) - cppr_pkg::PACKET_OVHD;
	assign sum     = {1'b0, tot_q} + SUM_W'(size_q);
	assign tot_ext = 32'(tot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q <= 10'd256;
			cap_q <= 24'd65536;
		end else if (cfg_we) begin
			if (cfg_addr == cppr_pkg::CFG_PACKET_SIZE) begin
				fps_q <= cfg_wdata[9:0];
			end else begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		fbc_d   = fbc_q;
		exp_d   = exp_q;
		tot_d   = tot_q;
		pn_d    = pn_q;
		size_d  = size_q;
		idx_d   = idx_q;
		base_d  = base_q;
		desc_d  = '0;
		len_ext = '0;
		bad_hdr = 1'b0;
		if (accept) begin
			case (req)
				cppr_pkg::REQ_START: begin
					phase_d = cppr_pkg::PH_ACK;
					fbc_d   = '0;
					exp_d   = '0;
					tot_d   = '0;
					pn_d    = '0;
					size_d  = '0;
					idx_d   = '0;
					base_d  = '0;
					desc_d  = cppr_pkg::frame_desc(cppr_pkg::BYTE_GET_PIC, cppr_pkg::BYTE_ONE,
						cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO);
				end
				cppr_pkg::REQ_TIMEOUT: begin
					if (phase_q != cppr_pkg::PH_IDLE) begin
						phase_d = cppr_pkg::PH_IDLE;
						desc_d  = cppr_pkg::add_status('0, cppr_pkg::ST_TIMEOUT, tot_ext[23:0]);
					end
				end
				cppr_pkg::REQ_BYTE: begin
					case (phase_q)
						cppr_pkg::PH_ACK: begin
							bad_hdr = (fbc_q == 3'd0 && rx != cppr_pkg::BYTE_SYNC) ||
								(fbc_q == 3'd1 && rx != cppr_pkg::BYTE_ACK) ||
								(fbc_q == 3'd2 && rx != cppr_pkg::BYTE_GET_PIC);
							if (bad_hdr) begin
								phase_d = cppr_pkg::PH_IDLE;
								desc_d  = cppr_pkg::add_status('0, cppr_pkg::ST_BAD, tot_ext[23:0]);
							end else if (fbc_q >= 3'(cppr_pkg::FRAME_BYTES - 1)) begin
								fbc_d   = '0;
								phase_d = cppr_pkg::PH_LEN;
							end else begin
								fbc_d = fbc_q + 3'd1;
							end
						end
						cppr_pkg::PH_LEN: begin
							bad_hdr = (fbc_q == 3'd0 && rx != cppr_pkg::BYTE_SYNC) ||
								(fbc_q == 3'd1 && rx != cppr_pkg::BYTE_LENGTH) ||
								(fbc_q == 3'd2 && rx != cppr_pkg::BYTE_ONE);
							if (bad_hdr) begin
								phase_d = cppr_pkg::PH_IDLE;
								desc_d  = cppr_pkg::add_status('0, cppr_pkg::ST_BAD, tot_ext[23:0]);
							end else begin
								case (fbc_q)
									3'd3:    exp_d = LEN_W'(rx);
									3'd4:    exp_d = exp_q | LEN_W'({rx, 8'h00});
									3'd5:    exp_d = exp_q | LEN_W'({rx, 16'h0000});
									default: exp_d = exp_q;
								endcase
								len_ext = 32'(exp_d);
								if (fbc_q >= 3'(cppr_pkg::FRAME_BYTES - 1)) begin
									fbc_d = '0;
									if (len_ext >= 32'(cap_q)) begin
										phase_d = cppr_pkg::PH_IDLE;
										desc_d  = cppr_pkg::add_status('0, cppr_pkg::ST_NOMEM,
											tot_ext[23:0]);
									end else begin
										pn_d    = '0;
										tot_d   = '0;
										phase_d = cppr_pkg::PH_HDR;
										desc_d  = cppr_pkg::frame_desc(cppr_pkg::BYTE_ACK,
											cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO,
											cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO);
									end
								end else begin
									fbc_d = fbc_q + 3'd1;
								end
							end
						end
						cppr_pkg::PH_HDR: begin
							if (fbc_q == 3'd2) begin
								size_d = {8'h00, rx};
							end else if (fbc_q == 3'd3) begin
								size_d = {rx, size_q[7:0]};
							end
							if (fbc_q >= 3'd3) begin
								fbc_d   = '0;
								idx_d   = '0;
								base_d  = step * {8'h00, pn_q};
								phase_d = (size_d == 16'd0) ? cppr_pkg::PH_VERIFY
									: cppr_pkg::PH_DATA;
							end else begin
								fbc_d = fbc_q + 3'd1;
							end
						end
						cppr_pkg::PH_DATA: begin
							desc_d        = '0;
							desc_d.wr     = 1'b1;
							desc_d.addr   = base_q + 24'(idx_q);
							desc_d.data   = rx;
							desc_d.nbeats = 3'd1;
							idx_d         = idx_q + 16'd1;
							if (idx_d >= size_q) begin
								fbc_d   = '0;
								phase_d = cppr_pkg::PH_VERIFY;
							end
						end
						cppr_pkg::PH_VERIFY: begin
							if (fbc_q >= 3'd1) begin
								fbc_d = '0;
								tot_d = sum[LEN_W-1:0];
								if (sum == {1'b0, exp_q}) begin
									phase_d = cppr_pkg::PH_IDLE;
									desc_d  = cppr_pkg::add_status(
										cppr_pkg::frame_desc(cppr_pkg::BYTE_ACK,
											cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO,
											cppr_pkg::BYTE_END, cppr_pkg::BYTE_END),
										cppr_pkg::ST_OK, 24'(32'(sum[LEN_W-1:0])));
								end else if (sum > {1'b0, exp_q}) begin
									phase_d = cppr_pkg::PH_IDLE;
									desc_d  = cppr_pkg::add_status('0, cppr_pkg::ST_OVERRUN,
										24'(32'(sum[LEN_W-1:0])));
								end else begin
									pn_d    = pn_q + 16'd1;
									phase_d = cppr_pkg::PH_HDR;
									desc_d  = cppr_pkg::frame_desc(cppr_pkg::BYTE_ACK,
										cppr_pkg::BYTE_ZERO, cppr_pkg::BYTE_ZERO,
										pn_d[7:0], pn_d[15:8]);
								end
							end else begin
								fbc_d = fbc_q + 3'd1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cppr_pkg::PH_IDLE;
			fbc_q      <= '0;
			exp_q      <= '0;
			tot_q      <= '0;
			pn_q       <= '0;
			size_q     <= '0;
			idx_q      <= '0;
			base_q     <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			exp_q   <= exp_d;
			tot_q   <= tot_d;
			pn_q    <= pn_d;
			size_q  <= size_d;
			idx_q   <= idx_d;
			base_q  <= base_d;
			if (accept && desc_d.nbeats != 3'd0) begin
				pend_vld_q <= 1'b1;
			end else if (take) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && desc_d.nbeats != 3'd0) begin
			pend_q <= desc_d;
		end
	end

	cppr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.pend     (pend_q),
		.pend_vld (pend_vld_q),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cppr_pkg::KIND_STAT |-> m_tlast)
		else $error("status beat without tlast");

	a_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cppr_pkg::KIND_WR |-> m_tlast)
		else $error("buffer write beat without tlast");

	a_packet_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cppr_pkg::PH_DATA |-> size_q != 16'd0 && idx_q < size_q)
		else $error("data phase with exhausted packet");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		fbc_q <= 3'd5)
		else $error("frame byte count out of range");

	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q && !take |=> pend_vld_q && !s_tready || take)
		else $error("pending results dropped");

endmodule

// ===== design/cppr_emit.sv =====
// ----------------------------------------------------------------------------
// Camera picture packet receiver: result beat sequencer
// Holds one result descriptor and sends its beats, one per cycle while m_tready
// is high, on the master stream; takes the next descriptor as the last beat leaves.
// ----------------------------------------------------------------------------
module cppr_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  cppr_pkg::desc_t    pend,
	input  logic               pend_vld,
	output logic               take,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [71:0]        m_tdata,  // tx_byte, write_addr, write_data, status, image_size
	output logic [1:0]         m_tuser,  // out_kind
	output logic               m_tlast
);

	cppr_pkg::desc_t act_q;
	logic [2:0]      idx_q;
	logic            busy_q;
	logic            last_beat;
	logic            done;
	logic [7:0]      tx_byte;
	cppr_pkg::kind_t kind;
	logic [7:0]      wbyte;
	logic [23:0]     waddr;
	logic [2:0]      st;
	logic [23:0]     size;

	assign last_beat = (idx_q == act_q.nbeats - 3'd1);
	assign done      = busy_q && m_tready && last_beat;
	assign take      = pend_vld && (!busy_q || done);
	assign m_tvalid  = busy_q;
	assign m_tlast   = last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= pend;
		end
	end

	always_comb begin
		case (idx_q)
			3'd0:    tx_byte = cppr_pkg::BYTE_SYNC;
			3'd1:    tx_byte = act_q.tx[0];
			3'd2:    tx_byte = act_q.tx[1];
			3'd3:    tx_byte = act_q.tx[2];
			3'd4:    tx_byte = act_q.tx[3];
			3'd5:    tx_byte = act_q.tx[4];
			default: tx_byte = cppr_pkg::BYTE_ZERO;
		endcase
	end

	always_comb begin
		kind  = cppr_pkg::KIND_STAT;
		wbyte = '0;
		waddr = '0;
		st    = '0;
		size  = '0;
		if (act_q.tx6 && idx_q < cppr_pkg::FRAME_BEATS) begin
			kind = cppr_pkg::KIND_TX;
		end else if (act_q.wr) begin
			kind  = cppr_pkg::KIND_WR;
			wbyte = act_q.data;
			waddr = act_q.addr;
		end else begin
			st   = act_q.st;
			size = act_q.size;
		end
	end

	assign m_tuser = kind;
	assign m_tdata = {5'd0, size, st, wbyte, waddr,
		(kind == cppr_pkg::KIND_TX) ? tx_byte : 8'd0};

endmodule

// ===== dv/camera_picture_packet_receiver_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera picture packet receiver checker
// Watches the register port and both streams. Each slave beat that is taken
// runs through a behavioral copy of the picture download protocol, which
// queues the master beats that it must cause. Each master beat that is taken
// is compared field by field with the oldest beat still awaited.
// ----------------------------------------------------------------------------
module camera_picture_packet_receiver_checker
	import cppr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,  // tx_byte, write_addr, write_data, status, image_size
	input  logic [1:0]  m_tuser,  // out_kind
	input  logic        m_tlast,
	output int          fail_count,
	output int          awaited_count
);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx;
		logic [23:0] addr;
		logic [7:0]  data;
		status_t     st;
		logic [23:0] size;
		logic        last;
	} engine_result_t;

	engine_result_t awaited_results[$];
	engine_result_t held;
	logic           held_valid;

	logic [9:0]  packet_size_reg;
	logic [23:0] capacity_reg;

	phase_t      dl_phase;
	logic [2:0]  byte_count;
	logic [23:0] image_length;
	logic [23:0] image_total;
	logic [15:0] packet_id;
	logic [15:0] payload_len;
	logic [15:0] data_index;
	logic [23:0] base_addr;

	task automatic clear_download_state();
		byte_count = '0;
		image_length = '0;
		image_total = '0;
		packet_id = '0;
		payload_len = '0;
		data_index = '0;
		base_addr = '0;
	endtask

	// The newest result is held back so that it can be marked last once the
	// beat that caused it is fully decoded.
	task automatic emit_result(input kind_t kind, input logic [7:0] tx,
			input logic [23:0] addr, input logic [7:0] data, input status_t st,
			input logic [23:0] size);
		if (held_valid)
			awaited_results.push_back(held);
		held.kind = kind;
		held.tx = tx;
		held.addr = addr;
		held.data = data;
		held.st = st;
		held.size = size;
		held.last = 1'b0;
		held_valid = 1'b1;
	endtask

	task automatic emit_frame(input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
		logic [5:0][7:0] frame;
		frame = {b5, b4, b3, b2, b1, BYTE_SYNC};
		for (int i = 0; i < 6; i++)
			emit_result(KIND_TX, frame[i], '0, '0, ST_OK, '0);
	endtask

	task automatic finish_download(input status_t st);
		emit_result(KIND_STAT, '0, '0, '0, st, image_total);
		dl_phase = PH_IDLE;
	endtask

	task automatic ack_packet();
		emit_frame(BYTE_ACK, BYTE_ZERO, BYTE_ZERO, packet_id[7:0], packet_id[15:8]);
	endtask

	task automatic take_camera_byte(input logic [7:0] b);
		logic [23:0] addr_stride;
		logic [24:0] sum;
		case (dl_phase)
			PH_ACK: begin
				if ((byte_count == 3'd0 && b != BYTE_SYNC) ||
						(byte_count == 3'd1 && b != BYTE_ACK) ||
						(byte_count == 3'd2 && b != BYTE_GET_PIC))
					finish_download(ST_BAD);
				else if (byte_count >= 3'd5) begin
					byte_count = '0;
					dl_phase = PH_LEN;
				end else
					byte_count++;
			end
			PH_LEN: begin
				if ((byte_count == 3'd0 && b != BYTE_SYNC) ||
						(byte_count == 3'd1 && b != BYTE_LENGTH) ||
						(byte_count == 3'd2 && b != BYTE_ONE))
					finish_download(ST_BAD);
				else begin
					if (byte_count == 3'd3)
						image_length = {16'd0, b};
					else if (byte_count == 3'd4)
						image_length[15:8] = b;
					else if (byte_count == 3'd5)
						image_length[23:16] = b;
					if (byte_count >= 3'd5) begin
						byte_count = '0;
						if (image_length >= capacity_reg)
							finish_download(ST_NOMEM);
						else begin
							packet_id = '0;
							image_total = '0;
							dl_phase = PH_HDR;
							ack_packet();
						end
					end else
						byte_count++;
				end
			end
			PH_HDR: begin
				if (byte_count == 3'd2)
					payload_len = {8'd0, b};
				else if (byte_count == 3'd3)
					payload_len[15:8] = b;
				if (byte_count >= 3'd3) begin
					addr_stride = {14'd0, packet_size_reg} - PACKET_OVHD;
					byte_count = '0;
					data_index = '0;
					base_addr = addr_stride * packet_id;
					dl_phase = (payload_len == '0) ? PH_VERIFY : PH_DATA;
				end else
					byte_count++;
			end
			PH_DATA: begin
				emit_result(KIND_WR, '0, base_addr + {8'd0, data_index}, b, ST_OK, '0);
				data_index++;
				if (data_index >= payload_len) begin
					byte_count = '0;
					dl_phase = PH_VERIFY;
				end
			end
			PH_VERIFY: begin
				if (byte_count >= 3'd1) begin
					sum = {1'b0, image_total} + {9'd0, payload_len};
					byte_count = '0;
					image_total = sum[23:0];
					if (sum == {1'b0, image_length}) begin
						emit_frame(BYTE_ACK, BYTE_ZERO, BYTE_ZERO, BYTE_END, BYTE_END);
						finish_download(ST_OK);
					end else if (sum > {1'b0, image_length})
						finish_download(ST_OVERRUN);
					else begin
						packet_id++;
						dl_phase = PH_HDR;
						ack_packet();
					end
				end else
					byte_count++;
			end
			default: ;
		endcase
	endtask

	task automatic decode_camera_beat(input logic [1:0] req, input logic [7:0] b);
		case (req)
			REQ_START: begin
				clear_download_state();
				dl_phase = PH_ACK;
				emit_frame(BYTE_GET_PIC, BYTE_ONE, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO);
			end
			REQ_BYTE:
				take_camera_byte(b);
			REQ_TIMEOUT:
				if (dl_phase != PH_IDLE)
					finish_download(ST_TIMEOUT);
			default: ;
		endcase
		if (held_valid) begin
			held.last = 1'b1;
			awaited_results.push_back(held);
			held_valid = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		engine_result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual tuser %h tdata %h",
				$time, m_tuser, m_tdata);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			check_field("out_kind", want.kind, m_tuser);
			check_field("tx_byte", want.tx, m_tdata[7:0]);
			check_field("write_addr", want.addr, m_tdata[31:8]);
			check_field("write_data", want.data, m_tdata[39:32]);
			check_field("status", want.st, m_tdata[42:40]);
			check_field("image_size", want.size, m_tdata[66:43]);
			check_field("tdata padding", '0, m_tdata[71:67]);
			check_field("last", want.last, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_size_reg = 10'd256;
			capacity_reg = 24'd65536;
			clear_download_state();
			dl_phase = PH_IDLE;
			awaited_results.delete();
			held_valid = 1'b0;
			fail_count = 0;
			awaited_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_PACKET_SIZE)
					packet_size_reg = cfg_wdata[9:0];
				else
					capacity_reg = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				decode_camera_beat(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
			awaited_count = awaited_results.size();
		end
	end

endmodule

// ===== dv/camera_picture_packet_receiver_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera picture packet receiver test
// Drives picture downloads into the engine: a short directed opening, then
// well-formed transfers with random lengths, packet splits and data,
// mixed with bad frames, oversize lengths, timeouts, restarts, overruns and
// random noise, across several packet size and buffer capacity settings.
// Both stream sides idle at random; the checker decides each result beat.
// ----------------------------------------------------------------------------
module camera_picture_packet_receiver_test;
	import cppr_pkg::*;

	typedef enum int {
		DL_CLEAN,
		DL_BAD_FRAME,
		DL_NO_MEMORY,
		DL_TIMEOUT,
		DL_RESTART,
		DL_OVERRUN,
		DL_NOISE,
		DL_KIND_COUNT
	} download_kind_t;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] value;
	} camera_beat_t;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [23:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int           fail_count;
	int           awaited_count;
	int           beats_sent;
	bit           source_quiet;
	bit           sink_quiet;
	logic [23:0]  capacity_now;
	camera_beat_t plan[$];

	camera_picture_packet_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	camera_picture_packet_receiver_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_quiet = !sink_quiet;
			stall = sink_quiet ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_beat(input logic [1:0] req, input logic [7:0] value);
		int gap;
		if ($urandom_range(0, 39) == 0)
			source_quiet = !source_quiet;
		gap = source_quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic settle_engine();
		s_tvalid <= 1'b0;
		while (awaited_count != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [23:0] size_word, input logic [23:0] capacity);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_PACKET_SIZE;
		cfg_wdata <= size_word;
		@(negedge clk);
		cfg_addr <= CFG_CAPACITY;
		cfg_wdata <= capacity;
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity_now = capacity;
	endtask

	task automatic plan_beat(input logic [1:0] req, input logic [7:0] value);
		camera_beat_t b;
		b.req = req;
		b.value = value;
		plan.push_back(b);
	endtask

	task automatic plan_bytes(input logic [47:0] bytes, input int count);
		for (int i = 0; i < count; i++)
			plan_beat(REQ_BYTE, bytes[8 * i +: 8]);
	endtask

	task automatic cut_plan(input int keep);
		while (plan.size() > keep)
			void'(plan.pop_back());
	endtask

	task automatic send_plan();
		camera_beat_t b;
		while (plan.size() > 0) begin
			b = plan.pop_front();
			send_beat(b.req, b.value);
		end
	endtask

	// A full transfer: command, acknowledge and length frames, then, for a
	// length under capacity, packets adding up to it or overshooting on the last.
	task automatic plan_download(input logic [23:0] length, input bit overrun);
		int remaining;
		int chunk;
		int packet;
		logic [15:0] tag;
		plan_beat(REQ_START, 8'($urandom));
		plan_bytes({24'($urandom), BYTE_GET_PIC, BYTE_ACK, BYTE_SYNC}, 6);
		plan_bytes({length, BYTE_ONE, BYTE_LENGTH, BYTE_SYNC}, 6);
		if (length >= capacity_now)
			return;
		remaining = length;
		packet = 0;
		do begin
			if (remaining == 0 || $urandom_range(0, 7) == 0)
				chunk = 0;
			else
				chunk = $urandom_range(1, 16);
			if (chunk > remaining)
				chunk = remaining;
			if (overrun && chunk == remaining)
				chunk += $urandom_range(1, 8);
			tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(packet);
			plan_bytes({16'(chunk), tag}, 4);
			repeat (chunk) plan_beat(REQ_BYTE, 8'($urandom));
			plan_bytes(16'($urandom), 2);
			remaining -= chunk;
			packet++;
		end while (remaining > 0);
	endtask

	initial begin
		int transfer;
		int pick;
		int pos;
		download_kind_t kind;
		camera_beat_t b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_PACKET_SIZE;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_START;
		beats_sent = 0;
		source_quiet = 1'b0;
		sink_quiet = 1'b0;
		capacity_now = 24'd65536;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apply_setting(24'd64, 24'h010000);

		plan_beat(REQ_BYTE, 8'hFF);
		plan_beat(REQ_TIMEOUT, 8'h00);
		plan_beat(REQ_UNUSED, 8'h5A);
		plan_beat(REQ_START, 8'h00);
		plan_bytes({8'h05, BYTE_ACK, BYTE_SYNC}, 3);
		plan_beat(REQ_START, 8'hFF);
		plan_bytes({24'h00FF00, BYTE_GET_PIC, BYTE_ACK, BYTE_SYNC}, 6);
		plan_bytes({24'h000000, BYTE_ONE, BYTE_LENGTH, BYTE_SYNC}, 6);
		plan_bytes({16'h0000, 16'hFFFF}, 4);
		plan_bytes(16'hFF00, 2);
		send_plan();

		for (transfer = 0; beats_sent < 330; transfer++) begin
			if (transfer % 2 == 0) begin
				settle_engine();
				case (transfer / 2)
					0: apply_setting(24'd512, 24'hFFFFFF);
					1: apply_setting(24'd3, 24'd5000);
					2: apply_setting(24'd64, 24'd40);
					3: apply_setting({14'($urandom), 10'd1023}, 24'd0);
					4: apply_setting(24'd0, 24'd1);
					default: apply_setting(24'($urandom),
						($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 60))
							: 24'($urandom));
				endcase
			end
			if (transfer < DL_KIND_COUNT)
				kind = download_kind_t'(transfer);
			else begin
				pick = $urandom_range(0, 9);
				kind = (pick < 4) ? DL_CLEAN : download_kind_t'(pick - 3);
			end
			case (kind)
				DL_BAD_FRAME: begin
					plan_download(24'($urandom_range(0, 30)), 1'b0);
					pos = $urandom_range(0, 5);
					pos = (pos < 3) ? pos + 1 : pos + 4;
					b = plan[pos];
					b.value = b.value ^ 8'($urandom_range(1, 255));
					plan[pos] = b;
					cut_plan(pos + 1);
				end
				DL_NO_MEMORY:
					plan_download(24'($urandom_range(capacity_now, 24'hFFFFFF)), 1'b0);
				DL_TIMEOUT: begin
					plan_download(24'($urandom_range(0, 30)), 1'b0);
					cut_plan($urandom_range(1, plan.size() - 1));
					plan_beat(REQ_TIMEOUT, 8'($urandom));
				end
				DL_RESTART: begin
					plan_download(24'($urandom_range(0, 30)), 1'b0);
					cut_plan($urandom_range(1, plan.size() - 1));
					plan_download(24'($urandom_range(0, 30)), 1'b0);
				end
				DL_OVERRUN:
					plan_download(24'($urandom_range(1, 30)), 1'b1);
				DL_NOISE: begin
					repeat (12) plan_beat(2'($urandom_range(0, 3)), 8'($urandom));
					plan_beat(REQ_TIMEOUT, 8'($urandom));
				end
				default:
					plan_download(24'($urandom_range(0, 30)), 1'b0);
			endcase
			send_plan();
		end

		s_tvalid <= 1'b0;
		while (awaited_count != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/cppr_pkg.sv
design/cppr_emit.sv
design/camera_picture_packet_receiver.sv
dv/camera_picture_packet_receiver_checker.sv
dv/camera_picture_packet_receiver_test.sv
